// ===== design/rprd_pkg.sv =====
// Shared types and constants of the partitioned Rice residual decoder.
package rprd_pkg;

    localparam int BLOCK_W = 17;
    localparam int ORDER_W = 6;
    localparam int VALUE_W = 32;

    localparam logic [4:0]  ESC_NARROW = 5'd15;
    localparam logic [4:0]  ESC_WIDE   = 5'd31;
    localparam logic [20:0] UNARY_CAP  = 21'h100000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_METHOD,
        PH_PORDER,
        PH_PARAM,
        PH_RAWW,
        PH_UNARY,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_METHOD,
        ST_BAD_SPLIT,
        ST_BAD_ORDER
    } t_status;

    // section parameters carried by a start beat
    typedef struct packed {
        logic [BLOCK_W-1:0] block_size;
        logic [ORDER_W-1:0] order;
        logic [2:0]         skip;
    } t_start_cmd;

    // one bitstream bit presented to the decoder
    typedef struct packed {
        logic       valid;
        logic       data;
        logic [2:0] spare;
    } t_bit_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] residual;
        logic [BLOCK_W-1:0]        run_length;
        logic                      last;
        t_status                   status;
        logic [2:0]                spare_bits;
    } t_result;

endpackage

// ===== design/rprd_byte_shifter.sv =====
// Input beat handling and the byte shift register feeding one bit per cycle while the decoder takes it.
module rprd_byte_shifter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [7:0]          i_data_byte,
    input  logic [16:0]         i_block_size,
    input  logic [5:0]          i_predictor_order,
    input  logic [2:0]          i_skip_bits,
    output logic                o_start_valid,
    output rprd_pkg::t_start_cmd o_start,
    output rprd_pkg::t_bit_beat  o_bit,
    input  logic                i_take,
    input  logic                i_drop
);
    import rprd_pkg::*;

    logic       r_busy;
    logic [7:0] r_byte;
    logic [2:0] r_pos;
    logic       accept;
    logic       finishing;

    // free again when the last bit goes this cycle or the decoder is idle
    assign finishing  = r_busy && (i_drop || (i_take && r_pos == 3'd0));
    assign o_in_ready = !r_busy || finishing;
    assign accept     = i_in_valid && o_in_ready;

    assign o_start_valid      = accept && !i_cmd;
    assign o_start.block_size = i_block_size;
    assign o_start.order      = i_predictor_order;
    assign o_start.skip       = i_skip_bits;

    assign o_bit.valid = r_busy;
    assign o_bit.data  = r_byte[7];
    assign o_bit.spare = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_byte <= '0;
            r_pos  <= '0;
        end else begin
            if (accept && i_cmd) begin
                r_busy <= 1'b1;
                r_byte <= i_data_byte;
                r_pos  <= 3'd7;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end else if (r_busy && i_take) begin
                r_byte <= {r_byte[6:0], 1'b0};
                r_pos  <= r_pos - 3'd1;
            end
        end
    end

endmodule

// ===== design/rprd_bit_engine.sv =====
// Bit-serial section parser: header fields, unary quotients and value fields.
module rprd_bit_engine #(
    parameter int MAX_BLOCK = 65536,
    parameter int MAX_ORDER = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start_valid,
    input  rprd_pkg::t_start_cmd i_start,
    input  rprd_pkg::t_bit_beat  i_bit,
    input  logic                 i_out_free,
    output logic                 o_take,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output rprd_pkg::t_result    o_res
);
    import rprd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [4:0]  r_bits_left, n_bits_left;
    logic        r_wide, n_wide;
    logic [3:0]  r_plog, n_plog;
    logic [14:0] r_pidx, n_pidx;
    logic [16:0] r_left, n_left;
    logic [16:0] r_part_size, n_part_size;
    logic [4:0]  r_param, n_param;
    logic [4:0]  r_escw, n_escw;
    logic [20:0] r_unary, n_unary;
    logic [16:0] r_block, n_block;
    logic [5:0]  r_order, n_order;

    logic        step;
    logic        fdone;
    logic        first_esc;
    logic [31:0] shifted;
    logic [4:0]  esc_code;
    logic        is_esc;
    logic [4:0]  param_left;
    logic [14:0] pmask;
    logic [14:0] new_mask;
    logic        last_part;
    logic [16:0] psize;
    logic [16:0] hd_left;
    logic [16:0] dec_left;
    logic        do_after_unary;
    logic        do_hdr;
    logic        do_resid;
    logic        do_start;
    logic        do_next;
    logic        next_emitted;
    logic [20:0] au_count;
    logic [31:0] resid_val;
    logic [4:0]  hd_param;
    logic [4:0]  hd_escw;
    logic [4:0]  s_param;
    logic [4:0]  s_escw;

    function automatic logic [31:0] unzigzag(input logic [31:0] v);
        logic [31:0] half;
        half = {1'b0, v[31:1]};
        return v[0] ? ~half : half;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_shift     <= '0;
            r_bits_left <= '0;
            r_wide      <= 1'b0;
            r_plog      <= '0;
            r_pidx      <= '0;
            r_left      <= '0;
            r_part_size <= '0;
            r_param     <= '0;
            r_escw      <= '0;
            r_unary     <= '0;
            r_block     <= '0;
            r_order     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_wide      <= n_wide;
            r_plog      <= n_plog;
            r_pidx      <= n_pidx;
            r_left      <= n_left;
            r_part_size <= n_part_size;
            r_param     <= n_param;
            r_escw      <= n_escw;
            r_unary     <= n_unary;
            r_block     <= n_block;
            r_order     <= n_order;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_wide      = r_wide;
        n_plog      = r_plog;
        n_pidx      = r_pidx;
        n_left      = r_left;
        n_part_size = r_part_size;
        n_param     = r_param;
        n_escw      = r_escw;
        n_unary     = r_unary;
        n_block     = r_block;
        n_order     = r_order;

        o_res_valid      = 1'b0;
        o_res.residual   = '0;
        o_res.run_length = 17'd1;
        o_res.last       = 1'b0;
        o_res.status     = ST_OK;
        o_res.spare_bits = i_bit.spare;

        do_after_unary = 1'b0;
        do_hdr         = 1'b0;
        do_resid       = 1'b0;
        do_start       = 1'b0;
        do_next        = 1'b0;
        next_emitted   = 1'b0;
        au_count       = '0;
        resid_val      = '0;
        hd_param       = r_param;
        hd_escw        = r_escw;
        s_param        = r_param;
        s_escw         = r_escw;
        hd_left        = '0;
        dec_left       = '0;

        esc_code   = r_wide ? ESC_WIDE : ESC_NARROW;
        is_esc     = r_param == esc_code;
        param_left = r_wide ? 5'd4 : 5'd3;
        pmask      = 15'((17'd1 << r_plog) - 17'd1);
        last_part  = r_pidx == pmask;
        step       = i_bit.valid && (r_phase != PH_IDLE) && i_out_free;
        fdone      = r_bits_left == 5'd0;

        // an escape value starts out as copies of its sign bit
        first_esc = (r_phase == PH_VALUE) && is_esc && (r_bits_left == r_escw - 5'd1);
        shifted   = first_esc ? {32{i_bit.data}} : {r_shift[30:0], i_bit.data};
        new_mask  = 15'((17'd1 << shifted[3:0]) - 17'd1);
        psize     = r_block >> shifted[3:0];

        if (step) begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_UNARY: begin
                    if (i_bit.data) begin
                        do_after_unary = 1'b1;
                        au_count       = r_unary;
                    end else begin
                        n_unary = r_unary + 21'd1;
                        // cap the quotient; the stop bit stays unread
                        if (r_unary == UNARY_CAP) begin
                            do_after_unary = 1'b1;
                            au_count       = r_unary + 21'd1;
                        end
                    end
                end
                default: begin
                    n_shift     = shifted;
                    n_bits_left = r_bits_left - 5'd1;
                    if (fdone) begin
                        case (r_phase)
                            PH_SKIP: begin
                                n_phase     = PH_METHOD;
                                n_shift     = '0;
                                n_bits_left = 5'd1;
                            end
                            PH_METHOD: begin
                                if (shifted[1]) begin
                                    o_res_valid  = 1'b1;
                                    o_res.last   = 1'b1;
                                    o_res.status = ST_BAD_METHOD;
                                    n_phase      = PH_IDLE;
                                end else begin
                                    n_wide      = shifted[0];
                                    n_phase     = PH_PORDER;
                                    n_shift     = '0;
                                    n_bits_left = 5'd3;
                                end
                            end
                            PH_PORDER: begin
                                n_plog = shifted[3:0];
                                if ((r_block[14:0] & new_mask) != 15'd0) begin
                                    o_res_valid  = 1'b1;
                                    o_res.last   = 1'b1;
                                    o_res.status = ST_BAD_SPLIT;
                                    n_phase      = PH_IDLE;
                                end else if ({11'd0, r_order} > psize) begin
                                    o_res_valid  = 1'b1;
                                    o_res.last   = 1'b1;
                                    o_res.status = ST_BAD_ORDER;
                                    n_phase      = PH_IDLE;
                                end else begin
                                    n_pidx      = '0;
                                    n_part_size = psize;
                                    n_phase     = PH_PARAM;
                                    n_shift     = '0;
                                    n_bits_left = param_left;
                                end
                            end
                            PH_PARAM: begin
                                n_param = shifted[4:0];
                                if (shifted[4:0] == esc_code) begin
                                    n_phase     = PH_RAWW;
                                    n_shift     = '0;
                                    n_bits_left = 5'd4;
                                end else begin
                                    do_hdr   = 1'b1;
                                    hd_param = shifted[4:0];
                                end
                            end
                            PH_RAWW: begin
                                n_escw  = shifted[4:0];
                                do_hdr  = 1'b1;
                                hd_escw = shifted[4:0];
                            end
                            PH_VALUE: begin
                                do_resid  = 1'b1;
                                resid_val = is_esc ? shifted : unzigzag(shifted);
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end

        // quotient done: with parameter zero it is the value, else load it so the low bits append to it
        if (do_after_unary) begin
            if (r_param == 5'd0) begin
                do_resid  = 1'b1;
                resid_val = unzigzag({11'd0, au_count});
            end else begin
                n_phase     = PH_VALUE;
                n_shift     = {11'd0, au_count};
                n_bits_left = r_param - 5'd1;
            end
        end

        if (do_hdr) begin
            hd_left = r_part_size - ((r_pidx == 15'd0) ? {11'd0, r_order} : 17'd0);
            if ((hd_param == esc_code) && (hd_escw == 5'd0)) begin
                if (hd_left != 17'd0) begin
                    o_res_valid      = 1'b1;
                    o_res.run_length = hd_left;
                    o_res.last       = last_part;
                end
                n_left       = '0;
                do_next      = 1'b1;
                next_emitted = hd_left != 17'd0;
            end else if (hd_left == 17'd0) begin
                do_next = 1'b1;
            end else begin
                n_left   = hd_left;
                do_start = 1'b1;
                s_param  = hd_param;
                s_escw   = hd_escw;
            end
        end

        if (do_resid) begin
            dec_left       = r_left - 17'd1;
            o_res_valid    = 1'b1;
            o_res.residual = resid_val;
            o_res.last     = (dec_left == 17'd0) && last_part;
            n_left         = dec_left;
            if (dec_left == 17'd0) begin
                do_next      = 1'b1;
                next_emitted = 1'b1;
            end else begin
                do_start = 1'b1;
            end
        end

        if (do_start) begin
            if (s_param == esc_code) begin
                n_phase     = PH_VALUE;
                n_shift     = '0;
                n_bits_left = s_escw - 5'd1;
            end else begin
                n_phase = PH_UNARY;
                n_unary = '0;
            end
        end

        if (do_next) begin
            if (last_part) begin
                // empty final partition: close the block with a marker
                if (!next_emitted) begin
                    o_res_valid      = 1'b1;
                    o_res.run_length = 17'd0;
                    o_res.last       = 1'b1;
                end
                n_phase = PH_IDLE;
            end else begin
                n_pidx      = r_pidx + 15'd1;
                n_phase     = PH_PARAM;
                n_shift     = '0;
                n_bits_left = param_left;
            end
        end

        if (i_start_valid) begin
            n_block     = (i_start.block_size > 17'(MAX_BLOCK)) ?
                          17'(MAX_BLOCK) : i_start.block_size;
            n_order     = (i_start.order > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : i_start.order;
            n_wide      = 1'b0;
            n_plog      = '0;
            n_pidx      = '0;
            n_left      = '0;
            n_param     = '0;
            n_escw      = '0;
            n_unary     = '0;
            n_shift     = '0;
            if (i_start.skip != 3'd0) begin
                n_phase     = PH_SKIP;
                n_bits_left = 5'(i_start.skip) - 5'd1;
            end else begin
                n_phase     = PH_METHOD;
                n_bits_left = 5'd1;
            end
        end
    end

    assign o_take = step;
    assign o_idle = r_phase == PH_IDLE;

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status != ST_OK) |-> o_res.last && (o_res.residual == '0))
        else $error("error result without last or with nonzero residual");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last && !i_start_valid |=> r_phase == PH_IDLE)
        else $error("section still active after its last result");

    a_pidx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> (r_pidx & ~pmask) == 15'd0)
        else $error("partition index beyond partition count");

    a_unary_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unary <= UNARY_CAP + 21'd1)
        else $error("unary count past its cap");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free && o_take)
        else $error("result produced without a consumed bit or output room");

endmodule

// ===== design/rprd_out_reg.sv =====
// Output register holding one result beat until the consumer takes it.
module rprd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  rprd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rprd_pkg::t_result o_res
);
    import rprd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== design/rice_partitioned_residual_decoder_top.sv =====
// Top level of the bit-serial partitioned Rice residual decoder.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | cmd, data_byte, block_size, order, skip
//  out     | output    | o_out_valid / i_out_ready  | residual, run_length, last, status, spare
//
//  A byte beat is decoded one bit per cycle while the output register has room; the
//  next beat is accepted in the cycle its last bit is consumed. A start beat passes
//  straight on to the bit engine. A byte that arrives with no section open is dropped.
//  Each bit yields at most one result; the bit engine holds while the output
//  register is full and not being taken.
//  Synchronous active-low reset clears all control state; the output data register
//  is only loaded with a result. No memories, no clearing pass.
module rice_partitioned_residual_decoder_top #(
    parameter int MAX_BLOCK = 65536,
    parameter int MAX_ORDER = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic [16:0]        i_block_size,
    input  logic [5:0]         i_predictor_order,
    input  logic [2:0]         i_skip_bits,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_residual,
    output logic [16:0]        o_run_length,
    output logic               o_last,
    output logic [1:0]         o_status,
    output logic [2:0]         o_spare_bits
);
    import rprd_pkg::*;

    logic       start_valid;
    t_start_cmd start_cmd;
    t_bit_beat  bit_beat;
    logic       take;
    logic       idle;
    logic       res_valid;
    t_result    res;
    logic       out_free;
    t_result    out_res;

    // byte beats become a serial bit stream; start beats pass straight on
    rprd_byte_shifter u_shifter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_data_byte       (i_data_byte),
        .i_block_size      (i_block_size),
        .i_predictor_order (i_predictor_order),
        .i_skip_bits       (i_skip_bits),
        .o_start_valid     (start_valid),
        .o_start           (start_cmd),
        .o_bit             (bit_beat),
        .i_take            (take),
        .i_drop            (idle)
    );

    // header fields and values shift in MSB first; quotients are counted in unary
    rprd_bit_engine #(
        .MAX_BLOCK (MAX_BLOCK),
        .MAX_ORDER (MAX_ORDER)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_valid (start_valid),
        .i_start       (start_cmd),
        .i_bit         (bit_beat),
        .i_out_free    (out_free),
        .o_take        (take),
        .o_idle        (idle),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // hold a finished result until the consumer takes it; decoding holds while it is full
    rprd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_residual   = out_res.residual;
    assign o_run_length = out_res.run_length;
    assign o_last       = out_res.last;
    assign o_status     = out_res.status;
    assign o_spare_bits = out_res.spare_bits;

endmodule

// ===== sim/rprd_checker.sv =====
// Channel monitor, result predictor and scoreboard for the partitioned Rice residual decoder.
`timescale 1ns / 100ps
module rprd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic [16:0]        i_block_size,
    input  logic [5:0]         i_predictor_order,
    input  logic [2:0]         i_skip_bits,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_residual,
    input  logic [16:0]        i_run_length,
    input  logic               i_last,
    input  logic [1:0]         i_status,
    input  logic [2:0]         i_spare_bits,
    output int                 o_fail_count,
    output int                 o_pending
);
    import rprd_pkg::*;

    localparam int         MAX_BLOCK    = 65536;
    localparam int         MAX_ORDER    = 32;
    localparam logic       CMD_START    = 1'b0;
    localparam logic [1:0] METHOD_WIDE  = 2'd1;

    // predictor state
    t_phase      dec_phase;
    logic [31:0] field_acc;
    logic [5:0]  field_len;
    logic [5:0]  field_got;
    logic        wide_mode;
    logic [3:0]  part_log2;
    logic [15:0] part_idx;
    logic [16:0] part_left;
    logic [4:0]  rice_k;
    logic [4:0]  raw_width;
    logic [20:0] zero_run;
    logic [16:0] blk_len;
    logic [5:0]  warmup;

    t_result expected_residuals[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void queue_result(logic [31:0] val, logic [16:0] run, logic last_flag,
                                         t_status st, logic [2:0] spare);
        t_result r;
        r.residual   = val;
        r.run_length = run;
        r.last       = last_flag;
        r.status     = st;
        r.spare_bits = spare;
        expected_residuals.push_back(r);
    endfunction

    function automatic logic [4:0] escape_code();
        return wide_mode ? ESC_WIDE : ESC_NARROW;
    endfunction

    function automatic logic [5:0] param_width();
        return wide_mode ? 6'd5 : 6'd4;
    endfunction

    function automatic logic [31:0] partitions();
        return 32'd1 << part_log2;
    endfunction

    function automatic logic is_final_partition();
        return ({16'd0, part_idx} + 32'd1) >= partitions();
    endfunction

    function automatic void open_field(t_phase ph, logic [5:0] len);
        dec_phase = ph;
        field_len = len;
        field_got = '0;
        field_acc = '0;
    endfunction

    function automatic void abort_section(t_status st, logic [2:0] spare);
        queue_result('0, 17'd1, 1'b1, st, spare);
        dec_phase = PH_IDLE;
    endfunction

    function automatic void begin_residual();
        if (rice_k == escape_code()) begin
            open_field(PH_VALUE, {1'b0, raw_width});
        end else begin
            zero_run  = '0;
            dec_phase = PH_UNARY;
        end
    endfunction

    // step to the next partition; close the block with a marker if nothing carried last
    function automatic void advance_partition(logic [2:0] spare, logic had_last);
        part_idx++;
        if ({16'd0, part_idx} >= partitions()) begin
            if (!had_last)
                queue_result('0, '0, 1'b1, ST_OK, spare);
            dec_phase = PH_IDLE;
        end else begin
            open_field(PH_PARAM, param_width());
        end
    endfunction

    function automatic void partition_header_done(logic [2:0] spare);
        logic [16:0] per_part;
        logic        final_part;
        logic        any_run;
        per_part   = blk_len >> part_log2;
        final_part = is_final_partition();
        part_left  = per_part - ((part_idx == 0) ? {11'd0, warmup} : 17'd0);
        if (rice_k == escape_code() && raw_width == 0) begin
            any_run = part_left != 0;
            if (any_run)
                queue_result('0, part_left, final_part, ST_OK, spare);
            part_left = '0;
            advance_partition(spare, any_run);
        end else if (part_left == 0) begin
            advance_partition(spare, 1'b0);
        end else begin
            begin_residual();
        end
    endfunction

    function automatic void residual_done(logic [31:0] val, logic [2:0] spare);
        logic ends_block;
        part_left--;
        ends_block = (part_left == 0) && is_final_partition();
        queue_result(val, 17'd1, ends_block, ST_OK, spare);
        if (part_left == 0)
            advance_partition(spare, 1'b1);
        else
            begin_residual();
    endfunction

    // fold quotient and remainder, then undo the zig-zag mapping
    function automatic void rice_done(logic [31:0] low, logic [2:0] spare);
        logic [31:0] folded;
        folded = ({11'd0, zero_run} << rice_k) | low;
        residual_done(folded[0] ? ~(folded >> 1) : (folded >> 1), spare);
    endfunction

    function automatic void after_unary(logic [2:0] spare);
        if (rice_k == 0)
            rice_done('0, spare);
        else
            open_field(PH_VALUE, {1'b0, rice_k});
    endfunction

    function automatic void field_complete(logic [2:0] spare);
        logic [31:0] v;
        v = field_acc;
        case (dec_phase)
            PH_SKIP: begin
                open_field(PH_METHOD, 6'd2);
            end
            PH_METHOD: begin
                if (v > METHOD_WIDE) begin
                    abort_section(ST_BAD_METHOD, spare);
                end else begin
                    wide_mode = v[0];
                    open_field(PH_PORDER, 6'd4);
                end
            end
            PH_PORDER: begin
                part_log2 = v[3:0];
                if (({15'd0, blk_len} & (partitions() - 32'd1)) != 0) begin
                    abort_section(ST_BAD_SPLIT, spare);
                end else if (warmup > (blk_len >> part_log2)) begin
                    abort_section(ST_BAD_ORDER, spare);
                end else begin
                    part_idx = '0;
                    open_field(PH_PARAM, param_width());
                end
            end
            PH_PARAM: begin
                rice_k = v[4:0];
                if (rice_k == escape_code())
                    open_field(PH_RAWW, 6'd5);
                else
                    partition_header_done(spare);
            end
            PH_RAWW: begin
                raw_width = v[4:0];
                partition_header_done(spare);
            end
            PH_VALUE: begin
                if (rice_k == escape_code()) begin
                    // sign-extend the raw value from its escape width
                    if (raw_width != 0 && v[raw_width - 1])
                        v = v | ~((32'd1 << raw_width) - 32'd1);
                    residual_done(v, spare);
                end else begin
                    rice_done(v, spare);
                end
            end
            default: begin
                dec_phase = PH_IDLE;
            end
        endcase
    endfunction

    function automatic void take_bit(logic b, logic [2:0] spare);
        if (dec_phase == PH_UNARY) begin
            if (b) begin
                after_unary(spare);
            end else begin
                zero_run++;
                // saturated quotient: leave the stop bit for the remainder
                if (zero_run > UNARY_CAP)
                    after_unary(spare);
            end
        end else begin
            field_acc = {field_acc[30:0], b};
            field_got++;
            if (field_got >= field_len)
                field_complete(spare);
        end
    endfunction

    function automatic void start_section(logic [16:0] bs, logic [5:0] po, logic [2:0] sk);
        blk_len   = (bs > MAX_BLOCK) ? 17'(MAX_BLOCK) : bs;
        warmup    = (po > MAX_ORDER) ? 6'(MAX_ORDER) : po;
        wide_mode = 1'b0;
        part_log2 = '0;
        part_idx  = '0;
        part_left = '0;
        rice_k    = '0;
        raw_width = '0;
        zero_run  = '0;
        if (sk != 0)
            open_field(PH_SKIP, {3'd0, sk});
        else
            open_field(PH_METHOD, 6'd2);
    endfunction

    function automatic void feed_byte(logic [7:0] byte_v);
        for (int b = 7; b >= 0 && dec_phase != PH_IDLE; b--)
            take_bit(byte_v[b], b[2:0]);
    endfunction

    function automatic void reset_predictor();
        dec_phase = PH_IDLE;
        field_acc = '0;
        field_len = '0;
        field_got = '0;
        wide_mode = 1'b0;
        part_log2 = '0;
        part_idx  = '0;
        part_left = '0;
        rice_k    = '0;
        raw_width = '0;
        zero_run  = '0;
        blk_len   = '0;
        warmup    = '0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_predictor();
            expected_residuals.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_START)
                    start_section(i_block_size, i_predictor_order, i_skip_bits);
                else
                    feed_byte(i_data_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_residuals.size() == 0) begin
                    o_fail_count++;
                    $error("unexpected result: residual 'h%0h run %0d last %0d status %0d",
                           i_residual, i_run_length, i_last, i_status);
                end else begin
                    want = expected_residuals.pop_front();
                    check_field("residual", want.residual, i_residual);
                    check_field("run_length", want.run_length, i_run_length);
                    check_field("last", want.last, i_last);
                    check_field("status", want.status, i_status);
                    check_field("spare_bits", want.spare_bits, i_spare_bits);
                end
            end
        end
        o_pending <= expected_residuals.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the partitioned Rice residual decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;
    import rprd_pkg::*;

    localparam int         RANDOM_ITEMS   = 190;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         TAIL_CYCLES    = 40;
    localparam logic       CMD_START      = 1'b0;
    localparam logic       CMD_BYTE       = 1'b1;
    localparam logic [1:0] METHOD_NARROW  = 2'd0;
    localparam logic [1:0] METHOD_WIDE    = 2'd1;
    localparam logic [1:0] METHOD_BAD_LO  = 2'd2;
    localparam logic [1:0] METHOD_BAD_HI  = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               in_cmd = CMD_START;
    logic [7:0]         in_byte = '0;
    logic [16:0]        in_block_size = '0;
    logic [5:0]         in_order = '0;
    logic [2:0]         in_skip = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] out_residual;
    logic [16:0]        out_run_length;
    logic               out_last;
    logic [1:0]         out_status;
    logic [2:0]         out_spare_bits;

    int fail_count;
    int pending;

    // flow-control knobs, written by the stimulus process right after a posedge
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    // bitstream of the section under construction, MSB first
    bit section_bits[$];

    always #5 clk = ~clk;

    rice_partitioned_residual_decoder_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (in_cmd),
        .i_data_byte       (in_byte),
        .i_block_size      (in_block_size),
        .i_predictor_order (in_order),
        .i_skip_bits       (in_skip),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_residual        (out_residual),
        .o_run_length      (out_run_length),
        .o_last            (out_last),
        .o_status          (out_status),
        .o_spare_bits      (out_spare_bits)
    );

    rprd_checker u_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_cmd             (in_cmd),
        .i_data_byte       (in_byte),
        .i_block_size      (in_block_size),
        .i_predictor_order (in_order),
        .i_skip_bits       (in_skip),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_residual        (out_residual),
        .i_run_length      (out_run_length),
        .i_last            (out_last),
        .i_status          (out_status),
        .i_spare_bits      (out_spare_bits),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Receiver: stall at the current rate, or hold ready low for a long
    // stretch when asked, so the output fills and the input backs up.
    always @(negedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one beat; idle first at the sender rate, then hold valid and
    // payload until the beat is taken.
    task automatic send_beat(logic cmd, logic [7:0] byte_v, logic [16:0] bs,
                             logic [5:0] ord, logic [2:0] sk);
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_cmd        <= cmd;
        in_byte       <= byte_v;
        in_block_size <= bs;
        in_order      <= ord;
        in_skip       <= sk;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Start a fresh bitstream with its leading skipped bits as random filler.
    task automatic open_section(int sk);
        section_bits.delete();
        repeat (sk) section_bits.push_back(1'($urandom_range(1)));
    endtask

    task automatic put_bits(logic [31:0] val, int n);
        for (int i = n - 1; i >= 0; i--)
            section_bits.push_back(val[i]);
    endtask

    task automatic put_header(logic [1:0] method, int porder);
        put_bits(32'(method), 2);
        put_bits(porder, 4);
    endtask

    // Unary quotient, stop bit, remainder. Past the cap the decoder stops
    // counting on its own, so no stop bit goes in.
    task automatic put_rice(int k, int q, logic [31:0] low);
        repeat (q) section_bits.push_back(1'b0);
        if (q <= UNARY_CAP)
            section_bits.push_back(1'b1);
        put_bits(low, k);
    endtask

    // Pad to a byte with random bits, send the start beat and the first
    // keep_bytes bytes (all of them when negative), then drop the stream.
    task automatic send_section(int bs, int ord, int sk, int keep_bytes);
        int         nbytes;
        int         nsend;
        logic [7:0] bv;
        while (section_bits.size() % 8 != 0)
            section_bits.push_back(1'($urandom_range(1)));
        nbytes = section_bits.size() / 8;
        nsend  = (keep_bytes < 0 || keep_bytes > nbytes) ? nbytes : keep_bytes;
        send_beat(CMD_START, 8'($urandom), 17'(bs), 6'(ord), 3'(sk));
        for (int i = 0; i < nsend; i++) begin
            for (int j = 0; j < 8; j++)
                bv[7 - j] = section_bits[i * 8 + j];
            send_beat(CMD_BYTE, bv, 17'($urandom), 6'($urandom), 3'($urandom));
        end
        items_sent += 1 + nsend;
        section_bits.delete();
    endtask

    // One partition: either an escape with a raw width (zero width included)
    // or a Rice parameter, biased small to keep the streams short.
    task automatic put_partition(logic wide, int count);
        int esc;
        int k;
        int w;
        int q;
        esc = int'(wide ? ESC_WIDE : ESC_NARROW);
        if ($urandom_range(3) == 0) begin
            put_bits(esc, wide ? 5 : 4);
            if ($urandom_range(3) == 0)
                w = 0;
            else
                w = ($urandom_range(2) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
            put_bits(w, 5);
            if (w != 0)
                repeat (count) put_bits($urandom, w);
        end else begin
            k = ($urandom_range(3) == 0) ? $urandom_range(esc - 1) : $urandom_range(3);
            put_bits(k, wide ? 5 : 4);
            repeat (count) begin
                q = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(3);
                put_rice(k, q, $urandom);
            end
        end
    endtask

    // Mostly well-formed sections with random content; the rest carry a bad
    // method, an uneven split, an oversized order, or get cut short.
    task automatic random_section();
        int         flavor;
        int         porder;
        int         parts;
        int         per;
        int         bs;
        int         ord;
        int         sk;
        logic [1:0] method;
        int         keep;
        flavor = $urandom_range(15);
        porder = (flavor == 1) ? $urandom_range(1, 3) : $urandom_range(3);
        parts  = 1 << porder;
        per    = $urandom_range(1, (porder >= 2) ? 3 : 6);
        bs     = per * parts;
        ord    = ($urandom_range(3) == 0) ? per : $urandom_range(per);
        sk     = $urandom_range(7);
        method = $urandom_range(1) ? METHOD_WIDE : METHOD_NARROW;
        keep   = -1;
        if (flavor == 0)
            method = $urandom_range(1) ? METHOD_BAD_HI : METHOD_BAD_LO;
        if (flavor == 1)
            bs = bs + $urandom_range(1, parts - 1);
        if (flavor == 2)
            ord = per + $urandom_range(1, 8);
        open_section(sk);
        put_header(method, porder);
        if (flavor > 2)
            for (int p = 0; p < parts; p++)
                put_partition(method[0], (p == 0) ? per - ord : per);
        // cut the stream short so the next start lands mid-section
        if (flavor == 3 && section_bits.size() > 16)
            keep = $urandom_range(1, section_bits.size() / 8 - 1);
        send_section(bs, ord, sk, keep);
        // stray byte: ignored once the section has ended
        if ($urandom_range(5) == 0)
            send_beat(CMD_BYTE, 8'($urandom), 17'($urandom), 6'($urandom), 3'($urandom));
    endtask

    task automatic run_directed();
        // byte with no section open
        send_beat(CMD_BYTE, 8'hA5, 17'h1FFFF, 6'h3F, 3'd7);

        // bad coding methods, at different bit positions
        open_section(0);
        put_bits(32'(METHOD_BAD_LO), 2);
        send_section(16, 0, 0, -1);
        open_section(6);
        put_bits(32'(METHOD_BAD_HI), 2);
        send_section(16, 0, 6, -1);

        // empty block: marker result after the only header
        open_section(1);
        put_header(METHOD_NARROW, 0);
        put_bits(5, 4);
        send_section(0, 0, 1, -1);

        // largest block as one zero-width escape run
        open_section(0);
        put_header(METHOD_WIDE, 0);
        put_bits(32'(ESC_WIDE), 5);
        put_bits(0, 5);
        send_section(65536, 0, 0, -1);

        // oversized block size and order saturate
        open_section(2);
        put_header(METHOD_NARROW, 0);
        put_bits(32'(ESC_NARROW), 4);
        put_bits(0, 5);
        send_section(131071, 63, 2, -1);

        // partition count does not divide the block
        open_section(4);
        put_header(METHOD_NARROW, 15);
        send_section(1, 0, 4, -1);

        // order larger than the first partition
        open_section(7);
        put_header(METHOD_WIDE, 15);
        send_section(65536, 3, 7, -1);

        // first and only partition empty: marker
        open_section(0);
        put_header(METHOD_NARROW, 0);
        put_bits(3, 4);
        send_section(4, 4, 0, -1);

        // widest escape values: extremes of the residual
        open_section(3);
        put_header(METHOD_WIDE, 0);
        put_bits(32'(ESC_WIDE), 5);
        put_bits(31, 5);
        put_bits(32'h3FFF_FFFF, 31);
        put_bits(32'h4000_0000, 31);
        put_bits(32'h0000_0000, 31);
        put_bits(32'h7FFF_FFFF, 31);
        send_section(4, 0, 3, -1);

        // one-bit escape values
        open_section(5);
        put_header(METHOD_NARROW, 0);
        put_bits(32'(ESC_NARROW), 4);
        put_bits(1, 5);
        put_bits(1, 1);
        put_bits(0, 1);
        send_section(2, 0, 5, -1);

        // largest wide parameter, quotient wraps the value
        open_section(0);
        put_header(METHOD_WIDE, 0);
        put_bits(30, 5);
        put_rice(30, 0, 32'h3FFF_FFFF);
        put_rice(30, 3, 0);
        put_rice(30, 5, $urandom);
        send_section(3, 0, 0, -1);

        // parameter zero and largest narrow parameter
        open_section(1);
        put_header(METHOD_NARROW, 0);
        put_bits(0, 4);
        put_rice(0, 0, 0);
        put_rice(0, 1, 0);
        put_rice(0, 2, 0);
        send_section(3, 0, 1, -1);
        open_section(6);
        put_header(METHOD_NARROW, 0);
        put_bits(14, 4);
        put_rice(14, 1, 32'h3FFF);
        put_rice(14, 0, 0);
        send_section(2, 0, 6, -1);

        // four partitions: Rice, zero-width escape mid-block, raw, Rice
        open_section(3);
        put_header(METHOD_NARROW, 2);
        put_bits(2, 4);
        put_rice(2, 1, 3);
        put_bits(32'(ESC_NARROW), 4);
        put_bits(0, 5);
        put_bits(32'(ESC_NARROW), 4);
        put_bits(4, 5);
        put_bits(8, 4);
        put_bits(7, 4);
        put_bits(0, 4);
        put_rice(0, 4, 0);
        put_rice(0, 0, 0);
        send_section(8, 1, 3, -1);

        // abandon a section mid-stream; the next start takes over
        open_section(0);
        put_header(METHOD_NARROW, 0);
        put_bits(2, 4);
        repeat (8) put_rice(2, 2, $urandom);
        send_section(8, 0, 0, 2);
    endtask

    initial begin
        int random_start;
        int phase;
        bit hold_done;
        hold_done = 1'b0;

        // hold reset, then release it at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // random part in four flow-control phases
        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            phase = (items_sent - random_start) * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // long receiver hold while the sender keeps offering
                    if (!hold_done && items_sent - random_start > 20) begin
                        hold_req++;
                        hold_done = 1'b1;
                    end
                end
                1: begin
                    tx_idle_pct  = 77;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
                default: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 10;
                end
            endcase
            random_section();
        end

        // drop valid, drain, then let the tail run out
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
